[rtl/linear_key_value_table_core_assert.svh]
// Assertion macros used by the checker of the key/value table.
`ifndef LINEAR_KEY_VALUE_TABLE_CORE_ASSERT_SVH
`define LINEAR_KEY_VALUE_TABLE_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define LKVT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define LKVT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lkvt_pkg.sv]
`timescale 1ns / 1ps

package lkvt_pkg;

    // Field widths of the item formats.
    localparam int FUNC_W      = 3;
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 32;
    localparam int COUNT_W     = 6;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 40;

    // Input tdata positions.
    localparam int IN_FUNC_LSB  = 0;
    localparam int IN_KEY_LSB   = IN_FUNC_LSB + FUNC_W;
    localparam int IN_VALUE_LSB = IN_KEY_LSB + KEY_W;
    localparam int IN_USED_W    = IN_VALUE_LSB + VALUE_W;

    // Output tdata positions.
    localparam int OUT_FOUND_BIT  = 0;
    localparam int OUT_VALUE_LSB  = 1;
    localparam int OUT_COUNT_LSB  = OUT_VALUE_LSB + VALUE_W;
    localparam int OUT_STATUS_BIT = OUT_COUNT_LSB + COUNT_W;

    // Operation codes; the two unused codes behave as a lookup.
    typedef enum logic [FUNC_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_UPDATE = 3'd1,
        OP_ACCESS = 3'd2,
        OP_WRITE  = 3'd3,
        OP_DELETE = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    // Result status codes.
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_EXEC   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

endpackage

[rtl/linear_key_value_table_core.sv]
`timescale 1ns / 1ps
// Key/value table of up to DEPTH entries, kept packed in insertion order in two
// single-port-read memories. Each item (operation, key, value) is searched for one
// entry per cycle through the memory read port, first match wins; a delete then
// moves each later entry down one place, again one entry per cycle through the same
// read and write ports. The input is not ready while an item is worked on and takes
// the next item once the result is registered. The result sits in an output register,
// so a new item is taken while it waits. A write or access of a missing key into a
// full table changes nothing and returns status 1. Keys compare on their low KEY_WIDTH
// bits and values keep their low VALUE_WIDTH bits; the count field shows the low six
// bits of the entry count.
module linear_key_value_table_core
    import lkvt_pkg::*;
#(
    parameter int DEPTH       = 32,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // func [2:0], key [34:3], new_value [66:35], zero padding [71:67]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // found [0], value_out [32:1], count [38:33], status [39]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready
);

    localparam int KU  = (KEY_WIDTH < KEY_W) ? KEY_WIDTH : KEY_W;
    localparam int VU  = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int IW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int CW1 = CW + 1;

    // Entry memories.
    logic [KU-1:0] key_mem [DEPTH];
    logic [VU-1:0] val_mem [DEPTH];

    state_t        state_reg, state_next;
    op_t           func_reg;
    logic [KU-1:0] key_reg;
    logic [VU-1:0] nv_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic          found_reg, found_next;
    logic [VU-1:0] hit_val_reg, hit_val_next;
    logic [VU-1:0] res_val_reg, res_val_next;
    logic          res_status_reg, res_status_next;

    logic [KU-1:0] key_rd_reg;
    logic [VU-1:0] val_rd_reg;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] wr_addr;
    logic          wr_key_en, wr_val_en;
    logic [KU-1:0] wr_key;
    logic [VU-1:0] wr_val;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_free;
    logic                   in_accept;
    logic                   last_search;
    logic                   last_shift;
    logic                   has_next;
    logic                   is_write;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign last_search = (CW1'(idx_reg) + CW1'(1)) == CW1'(count_reg);
    assign has_next    = (CW1'(idx_reg) + CW1'(1)) < CW1'(count_reg);
    assign last_shift  = (CW1'(idx_reg) + CW1'(2)) == CW1'(count_reg);
    assign is_write    = (func_reg == OP_WRITE);

    // Memory ports: one registered read and one write per cycle.
    always_ff @(posedge aclk) begin
        if (wr_key_en) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (wr_val_en) begin
            val_mem[wr_addr] <= wr_val;
        end
        key_rd_reg <= key_mem[rd_addr];
        val_rd_reg <= val_mem[rd_addr];
    end

    // Sequencer: search, execute, shift for a delete, then register the result.
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        found_next      = found_reg;
        hit_val_next    = hit_val_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        rd_addr         = '0;
        wr_addr         = idx_reg;
        wr_key_en       = 1'b0;
        wr_val_en       = 1'b0;
        wr_key          = key_rd_reg;
        wr_val          = val_rd_reg;

        unique case (state_reg)
            S_IDLE: begin
                rd_addr = '0;
                if (in_accept) begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    if (count_reg == '0) begin
                        state_next = S_EXEC;
                    end else begin
                        state_next = S_SEARCH;
                    end
                end
            end
            S_SEARCH: begin
                // The read data holds the entry at idx_reg.
                rd_addr = idx_reg + IW'(1);
                if (key_rd_reg == key_reg) begin
                    found_next   = 1'b1;
                    hit_val_next = val_rd_reg;
                    state_next   = S_EXEC;
                end else if (last_search) begin
                    state_next = S_EXEC;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_EXEC: begin
                rd_addr         = idx_reg + IW'(1);
                res_val_next    = '0;
                res_status_next = STATUS_OK;
                state_next      = S_RESULT;
                case (func_reg) inside
                    OP_UPDATE: begin
                        if (found_reg) begin
                            wr_val_en    = 1'b1;
                            wr_val       = nv_reg;
                            res_val_next = nv_reg;
                        end
                    end
                    OP_ACCESS, OP_WRITE: begin
                        if (found_reg) begin
                            wr_val_en    = is_write;
                            wr_val       = nv_reg;
                            res_val_next = is_write ? nv_reg : hit_val_reg;
                        end else if (count_reg < CW'(DEPTH)) begin
                            // Append the new entry behind the last one.
                            wr_addr      = count_reg[IW-1:0];
                            wr_key_en    = 1'b1;
                            wr_val_en    = 1'b1;
                            wr_key       = key_reg;
                            wr_val       = is_write ? nv_reg : '0;
                            res_val_next = is_write ? nv_reg : '0;
                            count_next   = count_reg + CW'(1);
                        end else begin
                            res_status_next = STATUS_FULL;
                        end
                    end
                    OP_DELETE: begin
                        if (found_reg) begin
                            if (has_next) begin
                                state_next = S_SHIFT;
                            end else begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                    end
                    OP_CLEAR: begin
                        count_next = '0;
                    end
                    default: begin
                        if (found_reg) begin
                            res_val_next = hit_val_reg;
                        end
                    end
                endcase
            end
            S_SHIFT: begin
                // The read data holds the entry one place above idx_reg.
                rd_addr   = idx_reg + IW'(2);
                wr_key_en = 1'b1;
                wr_val_en = 1'b1;
                if (last_shift) begin
                    count_next = count_reg - CW'(1);
                    state_next = S_RESULT;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_RESULT: begin
                rd_addr = '0;
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (state_reg == S_RESULT && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item fields, working registers and the output item.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            func_reg <= op_t'(s_tdata[IN_FUNC_LSB +: FUNC_W]);
            key_reg  <= s_tdata[IN_KEY_LSB +: KU];
            nv_reg   <= s_tdata[IN_VALUE_LSB +: VU];
        end
        idx_reg        <= idx_next;
        found_reg      <= found_next;
        hit_val_reg    <= hit_val_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        if (state_reg == S_RESULT && out_free) begin
            out_data_reg[OUT_FOUND_BIT]              <= found_reg;
            out_data_reg[OUT_VALUE_LSB +: VALUE_W]   <= VALUE_W'(res_val_reg);
            out_data_reg[OUT_COUNT_LSB +: COUNT_W]   <= COUNT_W'(count_reg);
            out_data_reg[OUT_STATUS_BIT]             <= res_status_reg;
        end
    end

endmodule

[rtl/lkvt_checker.sv]
`timescale 1ns / 1ps
`include "linear_key_value_table_core_assert.svh"

// Port-level checks of the key/value table.
module lkvt_checker
    import lkvt_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready
);

    // A waiting result item holds still.
    `LKVT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item changed while stalled")

    // The table works on one item at a time.
    `LKVT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input ready straight after an accepted item")

    // A refused insert reports the key as absent with a zero value.
    `LKVT_ASSERT_SAME(a_full_refusal, aclk, aresetn, m_tvalid && (m_tdata[OUT_STATUS_BIT] == STATUS_FULL), !m_tdata[OUT_FOUND_BIT] && (m_tdata[OUT_VALUE_LSB +: VALUE_W] == '0), "refused insert with found or value set")

    // The entry count never exceeds the capacity.
    `LKVT_ASSERT_SAME(a_count_range, aclk, aresetn, m_tvalid, 32'(m_tdata[OUT_COUNT_LSB +: COUNT_W]) <= 32'(DEPTH), "entry count above capacity")

endmodule

bind linear_key_value_table_core lkvt_checker #(
    .DEPTH (DEPTH)
) u_lkvt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
